### hdl/otm_pkg.sv
// ----------------------------------------------------------------------------
// otm_pkg
// Shared types and constants of the operand template matcher: request and
// result codes, character codes and the result record.
// ----------------------------------------------------------------------------
package otm_pkg;

	// request type of one input transaction
	localparam logic REQ_TEMPLATE = 1'b0;
	localparam logic REQ_SOURCE   = 1'b1;

	// result kind
	localparam logic KIND_ARG     = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// characters with a meaning in the template or the source
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// one result transaction
	typedef struct packed {
		logic       kind;
		logic       matched;
		logic [4:0] arg_index;
		logic [7:0] arg_start;
		logic [8:0] arg_length;
		logic       run_end;
	} result_t;

	// results produced by one processed item (cnt is 0, 1 or 2)
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

### hdl/otm_tmpl_mem.sv
// ----------------------------------------------------------------------------
// otm_tmpl_mem
// Template character store: one write port, two read ports with registered
// read data. A write to an address read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module otm_tmpl_mem #(
	parameter int TEMPLATE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(TEMPLATE_DEPTH)-1:0] waddr,
	input  logic [7:0]                        wdata,
	input  logic [$clog2(TEMPLATE_DEPTH)-1:0] raddr0,
	input  logic [$clog2(TEMPLATE_DEPTH)-1:0] raddr1,
	output logic [7:0]                        rdata0,
	output logic [7:0]                        rdata1
);

	logic [7:0] mem_q [TEMPLATE_DEPTH];
	logic [7:0] rdata0_q;
	logic [7:0] rdata1_q;

	// write port and two registered read ports with write forwarding
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0_q <= (we && waddr == raddr0) ? wdata : mem_q[raddr0];
		rdata1_q <= (we && waddr == raddr1) ? wdata : mem_q[raddr1];
	end

	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

### hdl/otm_scan.sv
// ----------------------------------------------------------------------------
// otm_scan
// Matcher state and the single-pass step for one item: template load or one
// source character against the template characters at the current position
// and the one after it. Emits up to two results per item.
// ----------------------------------------------------------------------------
module otm_scan #(
	parameter int TEMPLATE_DEPTH = 64,
	parameter int SOURCE_LIMIT   = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic                              req_type,
	input  logic [7:0]                        char_code,
	input  logic                              last,
	input  logic [7:0]                        tch0,
	input  logic [7:0]                        tch1,
	output logic                              mem_we,
	output logic [$clog2(TEMPLATE_DEPTH)-1:0] mem_waddr,
	output logic [7:0]                        mem_wdata,
	output logic [$clog2(TEMPLATE_DEPTH)-1:0] mem_raddr0,
	output logic [$clog2(TEMPLATE_DEPTH)-1:0] mem_raddr1,
	output otm_pkg::push_t                    push
);

	localparam int AW  = $clog2(TEMPLATE_DEPTH);
	localparam int TLW = $clog2(TEMPLATE_DEPTH + 1);
	localparam int SW  = $clog2(SOURCE_LIMIT + 1);
	localparam int LW  = (SW > 9) ? SW : 9;

	// scan modes
	localparam logic [2:0] MODE_LIT  = 3'd0;
	localparam logic [2:0] MODE_CAP  = 3'd1;
	localparam logic [2:0] MODE_QCAP = 3'd2;
	localparam logic [2:0] MODE_REST = 3'd3;
	localparam logic [2:0] MODE_FAIL = 3'd4;

	logic [2:0]     mode_q, mode_d, mode_c;
	logic [TLW-1:0] tlen_q, tlen_d, tlen_base;
	logic [TLW-1:0] tpos_q, tpos_d, tpos_p1, lit_pos;
	logic [7:0]     cbr_q, cbr_d;
	logic [7:0]     oq_q, oq_d;
	logic [SW-1:0]  spos_q, spos_d;
	logic [SW-1:0]  cbeg_q, cbeg_d, cbeg_c;
	logic [5:0]     ccnt_q, ccnt_d, ccnt_a;
	logic           loading_q, loading_d;

	logic           go_cap, go_lit, arg_v, fin_arg, ok;
	logic [7:0]     lit_ch;
	logic [LW-1:0]  arg_len, fin_len;
	otm_pkg::result_t arg_r, fin_r, vrd_r;

	// low byte of a source offset
	function automatic logic [7:0] arg_start_of(input logic [SW-1:0] ofs);
		logic [LW-1:0] wide;
		wide = LW'(ofs);
		return wide[7:0];
	endfunction

	assign tpos_p1 = tpos_q + TLW'(1);

	// one step of the matcher
	always_comb begin
		mode_d    = mode_q;
		tlen_d    = tlen_q;
		tpos_d    = tpos_q;
		cbr_d     = cbr_q;
		oq_d      = oq_q;
		spos_d    = spos_q;
		cbeg_d    = cbeg_q;
		ccnt_d    = ccnt_q;
		loading_d = loading_q;
		tlen_base = loading_q ? tlen_q : '0;
		mode_c    = mode_q;
		cbeg_c    = cbeg_q;
		go_cap    = 1'b0;
		go_lit    = 1'b0;
		arg_v     = 1'b0;
		fin_arg   = 1'b0;
		ok        = 1'b0;
		lit_pos   = tpos_q;
		lit_ch    = tch0;
		arg_len   = '0;
		fin_len   = '0;
		ccnt_a    = ccnt_q;
		mem_we    = 1'b0;
		mem_waddr = tlen_base[AW-1:0];
		mem_wdata = char_code;
		push      = '0;
		arg_r     = '0;
		fin_r     = '0;
		vrd_r     = '0;

		if (fire && req_type == otm_pkg::REQ_TEMPLATE) begin
			// template load: append, drop beyond depth, restart the line
			loading_d = ~last;
			tlen_d    = tlen_base;
			if (tlen_base < TLW'(TEMPLATE_DEPTH)) begin
				mem_we = 1'b1;
				tlen_d = tlen_base + TLW'(1);
			end
			mode_d = MODE_LIT;
			tpos_d = '0;
			cbr_d  = '0;
			oq_d   = '0;
			spos_d = '0;
			cbeg_d = '0;
			ccnt_d = '0;
		end else if (fire) begin
			loading_d = 1'b0;
			if (spos_q >= SW'(SOURCE_LIMIT)) begin
				mode_c = MODE_FAIL;
			end else begin
				spos_d = spos_q + SW'(1);
			end
			mode_d = mode_c;

			// first pass by mode
			case (mode_c)
				MODE_LIT: begin
					if (tpos_q >= tlen_q) begin
						mode_d = MODE_FAIL;
					end else if (tch0 == otm_pkg::CH_AT) begin
						cbeg_d = spos_q;
						cbeg_c = spos_q;
						tpos_d = tpos_p1;
						if (tpos_p1 < tlen_q && tch1 == otm_pkg::CH_AT) begin
							mode_d = MODE_REST;
						end else if (char_code == otm_pkg::CH_DQUOTE ||
								char_code == otm_pkg::CH_SQUOTE) begin
							oq_d   = char_code;
							mode_d = MODE_QCAP;
						end else begin
							go_cap  = 1'b1;
							lit_pos = tpos_p1;
							lit_ch  = tch1;
						end
					end else begin
						go_lit = 1'b1;
					end
				end
				MODE_CAP: begin
					go_cap = 1'b1;
				end
				MODE_QCAP: begin
					if (char_code == oq_q) begin
						arg_v   = 1'b1;
						arg_len = LW'(spos_q) + LW'(1) - LW'(cbeg_q);
						mode_d  = MODE_LIT;
					end
				end
				default: begin
				end
			endcase

			// unquoted capture: a comma or the closing bracket ends it
			if (go_cap) begin
				if (char_code == otm_pkg::CH_COMMA || char_code == cbr_q) begin
					arg_v   = 1'b1;
					arg_len = LW'(spos_q) - LW'(cbeg_c);
					if (lit_pos >= tlen_q) begin
						mode_d = MODE_FAIL;
					end else begin
						go_lit = 1'b1;
					end
				end else begin
					mode_d = MODE_CAP;
				end
			end

			// literal compare, tracking the bracket that closes an argument
			if (go_lit) begin
				if (lit_ch == otm_pkg::CH_LBRACK) begin
					cbr_d = otm_pkg::CH_RBRACK;
				end else if (lit_ch == otm_pkg::CH_LPAREN) begin
					cbr_d = otm_pkg::CH_RPAREN;
				end else begin
					cbr_d = '0;
				end
				if (char_code != lit_ch) begin
					mode_d = MODE_FAIL;
				end else begin
					mode_d = MODE_LIT;
					tpos_d = lit_pos + TLW'(1);
				end
			end

			arg_r.kind       = otm_pkg::KIND_ARG;
			arg_r.arg_index  = ccnt_q[4:0];
			arg_r.arg_start  = arg_start_of(cbeg_c);
			arg_r.arg_length = arg_len[8:0];
			ccnt_a           = ccnt_q + 6'(arg_v);
			ccnt_d           = ccnt_a;

			if (last) begin
				// end of line: open argument, then verdict
				case (mode_d)
					MODE_LIT: begin
						ok = (tpos_d == tlen_q);
					end
					MODE_CAP: begin
						fin_arg = 1'b1;
						ok      = (tpos_d == tlen_q);
					end
					MODE_REST: begin
						fin_arg = 1'b1;
						ok      = 1'b1;
					end
					default: begin
						ok = 1'b0;
					end
				endcase
				fin_len          = LW'(spos_q) + LW'(1) - LW'(cbeg_d);
				fin_r.kind       = otm_pkg::KIND_ARG;
				fin_r.arg_index  = ccnt_a[4:0];
				fin_r.arg_start  = arg_start_of(cbeg_d);
				fin_r.arg_length = fin_len[8:0];
				vrd_r.kind       = otm_pkg::KIND_VERDICT;
				vrd_r.matched    = ok;
				vrd_r.run_end    = 1'b1;
				if (arg_v) begin
					push.cnt = 2'd2;
					push.r0  = arg_r;
					push.r1  = vrd_r;
				end else if (fin_arg) begin
					push.cnt = 2'd2;
					push.r0  = fin_r;
					push.r1  = vrd_r;
				end else begin
					push.cnt = 2'd1;
					push.r0  = vrd_r;
				end
				mode_d = MODE_LIT;
				tpos_d = '0;
				cbr_d  = '0;
				oq_d   = '0;
				spos_d = '0;
				cbeg_d = '0;
				ccnt_d = '0;
			end else if (arg_v) begin
				arg_r.run_end = 1'b1;
				push.cnt      = 2'd1;
				push.r0       = arg_r;
			end
		end
	end

	// template reads follow the next position
	assign mem_raddr0 = tpos_d[AW-1:0];
	assign mem_raddr1 = tpos_d[AW-1:0] + AW'(1);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_LIT;
			tlen_q    <= '0;
			tpos_q    <= '0;
			cbr_q     <= '0;
			oq_q      <= '0;
			spos_q    <= '0;
			cbeg_q    <= '0;
			ccnt_q    <= '0;
			loading_q <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			tlen_q    <= tlen_d;
			tpos_q    <= tpos_d;
			cbr_q     <= cbr_d;
			oq_q      <= oq_d;
			spos_q    <= spos_d;
			cbeg_q    <= cbeg_d;
			ccnt_q    <= ccnt_d;
			loading_q <= loading_d;
		end
	end

	// a line end always closes with a verdict
	a_line_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type == otm_pkg::REQ_SOURCE && last |->
			(push.cnt == 2'd1 && push.r0.kind == otm_pkg::KIND_VERDICT) ||
			(push.cnt == 2'd2 && push.r1.kind == otm_pkg::KIND_VERDICT))
		else $error("line end without verdict");

	// after a line end the run starts over
	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type == otm_pkg::REQ_SOURCE && last |=>
			spos_q == '0 && mode_q == MODE_LIT && ccnt_q == '0)
		else $error("run state not cleared after line end");

	// a template load restarts the line
	a_load_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type == otm_pkg::REQ_TEMPLATE |=>
			tpos_q == '0 && mode_q == MODE_LIT && tlen_q != '0)
		else $error("template load left run state");

endmodule

### hdl/otm_res_fifo.sv
// ----------------------------------------------------------------------------
// otm_res_fifo
// Four-entry result queue: takes up to two results per cycle, delivers one
// per output transaction, and tells the scan stage when two slots are free.
// ----------------------------------------------------------------------------
module otm_res_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  otm_pkg::push_t    push,
	input  logic              out_ready,
	output logic              out_valid,
	output otm_pkg::result_t  out_res,
	output logic              room
);

	localparam int FD = 4;

	otm_pkg::result_t ent_q [FD];
	logic [1:0] head_q, tail_q;
	logic [2:0] count_q, count_after_pop;
	logic       pop;

	assign out_valid       = (count_q != 3'd0);
	assign out_res         = ent_q[head_q];
	assign pop             = out_valid && out_ready;
	assign count_after_pop = count_q - 3'(pop);
	assign room            = (count_after_pop <= 3'(FD - 2));

	// result storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			ent_q[tail_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			ent_q[tail_q + 2'd1] <= push.r1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_q + 2'(pop);
			tail_q  <= tail_q + push.cnt;
			count_q <= count_after_pop + 3'(push.cnt);
		end
	end

	// the scan stage only pushes into free slots
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> count_after_pop + 3'(push.cnt) <= 3'(FD))
		else $error("result queue overflow");

endmodule

### hdl/operand_template_matcher_core.sv
// ----------------------------------------------------------------------------
// operand_template_matcher_core
// Matches streamed source lines against a stored template and reports the
// captured arguments and a verdict per line.
// ----------------------------------------------------------------------------
// Every input transaction, template character or source character, is
// registered in the input stage and processed, once the result queue has room,
// against the template characters at the current match position and the
// one after it (read from a two-port store whose addresses come from the
// next position), and its results go into a four-entry result queue. A new
// item is accepted in every cycle as long as the queue has room for two
// results; results leave at one per output transaction, so an item that
// ends an argument or a line needs one transaction per result. Template
// loads give no results. Results are registered in the queue before they
// are offered. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module operand_template_matcher_core #(
	parameter int TEMPLATE_DEPTH = 64,
	parameter int SOURCE_LIMIT   = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] char_code,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic       matched,
	output logic [4:0] arg_index,
	output logic [7:0] arg_start,
	output logic [8:0] arg_length,
	output logic       run_end
);

	localparam int AW = $clog2(TEMPLATE_DEPTH);

	logic          in_valid_s1;
	logic          req_type_s1;
	logic [7:0]    char_code_s1;
	logic          last_s1;
	logic          fire;
	logic          room;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr0, mem_raddr1;
	logic [7:0]    mem_wdata, tch0, tch1;
	otm_pkg::push_t   push;
	otm_pkg::result_t out_res;

	// input stage: processed when the result queue has room
	assign fire     = in_valid_s1 && room;
	assign in_ready = !in_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1  <= req_type;
			char_code_s1 <= char_code;
			last_s1      <= last;
		end
	end

	otm_tmpl_mem #(
		.TEMPLATE_DEPTH(TEMPLATE_DEPTH)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr0 (mem_raddr0),
		.raddr1 (mem_raddr1),
		.rdata0 (tch0),
		.rdata1 (tch1)
	);

	otm_scan #(
		.TEMPLATE_DEPTH(TEMPLATE_DEPTH),
		.SOURCE_LIMIT  (SOURCE_LIMIT)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req_type   (req_type_s1),
		.char_code  (char_code_s1),
		.last       (last_s1),
		.tch0       (tch0),
		.tch1       (tch1),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr0 (mem_raddr0),
		.mem_raddr1 (mem_raddr1),
		.push       (push)
	);

	otm_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res),
		.room      (room)
	);

	// result fields
	assign kind       = out_res.kind;
	assign matched    = out_res.matched;
	assign arg_index  = out_res.arg_index;
	assign arg_start  = out_res.arg_start;
	assign arg_length = out_res.arg_length;
	assign run_end    = out_res.run_end;

endmodule

### sim/tb_operand_template_matcher_core.sv
// ----------------------------------------------------------------------------
// tb_operand_template_matcher_core
// Self-checking bench for the operand template matcher. Template texts and
// source lines are queued up front: first a directed set of corner cases,
// then random instruction-like templates with lines that mostly fit them and
// partly don't. A behavioral predictor runs on every accepted input
// transaction and the monitor compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb_operand_template_matcher_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TDEPTH      = 64;
	localparam int SLIMIT      = 256;
	localparam int RAND_ITEMS  = 250;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 3000;
	localparam int TAIL_CYCLES = 20;

	typedef enum logic [2:0] {SCAN_LIT, SCAN_CAP, SCAN_QCAP, SCAN_REST, SCAN_FAIL} scan_mode_t;
	typedef logic [7:0] byte_q_t[$];
	typedef struct {
		logic       rq;
		logic [7:0] ch;
		logic       lst;
		bit         drain;   // wait until all results are in before offering
		bit         hold;    // start the long receiver hold-off
	} item_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic       req_type   = 1'b0;
	logic [7:0] char_code  = 8'h00;
	logic       last       = 1'b0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic       kind;
	logic       matched;
	logic [4:0] arg_index;
	logic [7:0] arg_start;
	logic [8:0] arg_length;
	logic       run_end;

	item_t            pend_q[$];
	otm_pkg::result_t expected_q[$];
	int               err_count = 0;
	bit               drain_next = 1'b0;
	bit               hold_next = 1'b0;
	logic             hold_toggle = 1'b0;

	// predictor state
	logic [7:0]       tmpl_mem [TDEPTH];
	int               tmpl_len;
	bit               tmpl_loading;
	int               tmpl_pos;
	logic [7:0]       close_br;
	scan_mode_t       mode;
	logic [7:0]       quote_ch;
	int               src_pos;
	int               cap_begin;
	int               cap_count;
	otm_pkg::result_t step_res [2];
	int               step_n;

	operand_template_matcher_core #(
		.TEMPLATE_DEPTH(TDEPTH),
		.SOURCE_LIMIT  (SLIMIT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.matched   (matched),
		.arg_index (arg_index),
		.arg_start (arg_start),
		.arg_length(arg_length),
		.run_end   (run_end)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_error(input string msg);
		if (err_count < 40)
			$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// append one byte to a byte queue
	function automatic void put_byte(ref byte_q_t q, input logic [7:0] b);
		q.insert(q.size(), b);
	endfunction

	// ------------------------------------------------------------------
	// Matcher predictor
	// ------------------------------------------------------------------
	task automatic restart_line();
		tmpl_pos  = 0;
		close_br  = 8'h00;
		mode      = SCAN_LIT;
		quote_ch  = 8'h00;
		src_pos   = 0;
		cap_begin = 0;
		cap_count = 0;
	endtask

	task automatic add_result(input otm_pkg::result_t r);
		if (step_n < 2) begin
			step_res[step_n] = r;
			step_n++;
		end
	endtask

	task automatic record_arg(input int len);
		otm_pkg::result_t r;
		r            = '0;
		r.kind       = otm_pkg::KIND_ARG;
		r.arg_index  = cap_count[4:0];
		r.arg_start  = cap_begin[7:0];
		r.arg_length = len[8:0];
		add_result(r);
		cap_count = (cap_count + 1) % 64;
	endtask

	task automatic predict_match(input logic rq, input logic [7:0] c, input logic lst);
		int               p;
		bit               done;
		bit               ok;
		logic [7:0]       t;
		otm_pkg::result_t r;
		step_n = 0;
		// template character: append, and drop any line in progress
		if (rq == otm_pkg::REQ_TEMPLATE) begin
			if (!tmpl_loading) begin
				tmpl_len     = 0;
				tmpl_loading = 1'b1;
			end
			if (tmpl_len < TDEPTH) begin
				tmpl_mem[tmpl_len] = c;
				tmpl_len++;
			end
			if (lst)
				tmpl_loading = 1'b0;
			restart_line();
			return;
		end
		tmpl_loading = 1'b0;
		p = src_pos;
		if (p >= SLIMIT)
			mode = SCAN_FAIL;
		else
			src_pos = p + 1;
		// a closing comma or bracket hands the character back to literal matching
		done = 1'b0;
		for (int g = 0; !done && g < 2 * TDEPTH + 4; g++) begin
			case (mode)
				SCAN_LIT: begin
					if (tmpl_pos >= tmpl_len) begin
						mode = SCAN_FAIL;
						done = 1'b1;
					end else begin
						t = tmpl_mem[tmpl_pos];
						if (t == otm_pkg::CH_AT) begin
							tmpl_pos++;
							cap_begin = p;
							if (tmpl_pos < tmpl_len && tmpl_mem[tmpl_pos] == otm_pkg::CH_AT) begin
								mode = SCAN_REST;
								done = 1'b1;
							end else if (c == otm_pkg::CH_DQUOTE || c == otm_pkg::CH_SQUOTE) begin
								quote_ch = c;
								mode     = SCAN_QCAP;
								done     = 1'b1;
							end else begin
								mode = SCAN_CAP;
							end
						end else begin
							close_br = (t == otm_pkg::CH_LBRACK) ? otm_pkg::CH_RBRACK :
							           (t == otm_pkg::CH_LPAREN) ? otm_pkg::CH_RPAREN : 8'h00;
							if (c != t)
								mode = SCAN_FAIL;
							else
								tmpl_pos++;
							done = 1'b1;
						end
					end
				end
				SCAN_CAP: begin
					if (c == otm_pkg::CH_COMMA || c == close_br) begin
						record_arg(p - cap_begin);
						mode = SCAN_LIT;
					end else begin
						done = 1'b1;
					end
				end
				SCAN_QCAP: begin
					if (c == quote_ch) begin
						record_arg(p + 1 - cap_begin);
						mode = SCAN_LIT;
					end
					done = 1'b1;
				end
				default: done = 1'b1;
			endcase
		end
		if (!done)
			mode = SCAN_FAIL;
		// end of line: flush an open argument, then the verdict
		if (lst) begin
			ok = 1'b0;
			case (mode)
				SCAN_LIT: ok = (tmpl_pos == tmpl_len);
				SCAN_CAP: begin
					record_arg(p + 1 - cap_begin);
					ok = (tmpl_pos == tmpl_len);
				end
				SCAN_REST: begin
					record_arg(p + 1 - cap_begin);
					ok = 1'b1;
				end
				default: ok = 1'b0;
			endcase
			if (step_n >= 2)
				step_n = 1;
			r         = '0;
			r.kind    = otm_pkg::KIND_VERDICT;
			r.matched = ok;
			add_result(r);
			restart_line();
		end
		if (step_n > 0)
			step_res[step_n - 1].run_end = 1'b1;
		for (int i = 0; i < step_n; i++)
			expected_q.insert(expected_q.size(), step_res[i]);
	endtask

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic void add_text(ref byte_q_t q, input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(q, s[i]);
	endfunction

	task automatic queue_bytes(input logic rq, input byte_q_t b, input bit with_last);
		item_t it;
		for (int i = 0; i < b.size(); i++) begin
			it.rq    = rq;
			it.ch    = b[i];
			it.lst   = with_last && (i == b.size() - 1);
			it.drain = drain_next && (i == 0);
			it.hold  = hold_next && (i == 0);
			pend_q.insert(pend_q.size(), it);
		end
		drain_next = 1'b0;
		hold_next  = 1'b0;
	endtask

	task automatic queue_text(input logic rq, input string s, input bit with_last);
		byte_q_t b;
		add_text(b, s);
		queue_bytes(rq, b, with_last);
	endtask

	// mnemonic plus a short operand list, sometimes plain noise
	function automatic byte_q_t gen_template();
		byte_q_t tm;
		int      nops;
		int      roll;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			repeat ($urandom_range(1, 8))
				put_byte(tm, ($urandom_range(0, 9) < 4) ? otm_pkg::CH_AT :
				             8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 4))
				put_byte(tm, 8'h61 + 8'($urandom_range(0, 25)));
			if (roll < 88) begin
				put_byte(tm, 8'h20);
				nops = $urandom_range(0, 3);
				for (int k = 0; k < nops; k++) begin
					if (k > 0)
						put_byte(tm, otm_pkg::CH_COMMA);
					if (k == nops - 1 && $urandom_range(0, 6) == 0) begin
						add_text(tm, "@@");
					end else begin
						case ($urandom_range(0, 4))
							0: add_text(tm, "@");
							1: add_text(tm, "[@]");
							2: add_text(tm, "(@)");
							3: begin
								put_byte(tm, 8'h72);
								put_byte(tm, 8'h30 + 8'($urandom_range(0, 9)));
							end
							default: add_text(tm, "#@");
						endcase
					end
				end
			end
		end
		return tm;
	endfunction

	// a source line that fits the template, with random argument text
	function automatic byte_q_t gen_line(input byte_q_t tm);
		byte_q_t    ln;
		logic [7:0] close_ch;
		logic [7:0] q;
		logic [7:0] b;
		int         i;
		int         n;
		close_ch = 8'h00;
		i = 0;
		while (i < tm.size()) begin
			if (tm[i] == otm_pkg::CH_AT) begin
				if (i + 1 < tm.size() && tm[i + 1] == otm_pkg::CH_AT) begin
					repeat ($urandom_range(1, 8))
						put_byte(ln, 8'($urandom_range(0, 255)));
					break;
				end
				if ($urandom_range(0, 9) < 3) begin
					q = $urandom_range(0, 1) ? otm_pkg::CH_DQUOTE : otm_pkg::CH_SQUOTE;
					put_byte(ln, q);
					repeat ($urandom_range(0, 4)) begin
						do b = 8'($urandom_range(0, 255)); while (b == q);
						put_byte(ln, b);
					end
					put_byte(ln, q);
				end else begin
					n = $urandom_range(0, 4);
					if (i == tm.size() - 1 && n == 0)
						n = 1;
					repeat (n) begin
						do b = 8'($urandom_range(0, 255));
						while (b == otm_pkg::CH_COMMA || b == close_ch ||
						       b == otm_pkg::CH_DQUOTE || b == otm_pkg::CH_SQUOTE);
						put_byte(ln, b);
					end
				end
			end else begin
				put_byte(ln, tm[i]);
				close_ch = (tm[i] == otm_pkg::CH_LBRACK) ? otm_pkg::CH_RBRACK :
				           (tm[i] == otm_pkg::CH_LPAREN) ? otm_pkg::CH_RPAREN : 8'h00;
			end
			i++;
		end
		if (ln.size() == 0)
			put_byte(ln, 8'h78);
		return ln;
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of transactions with random gaps
	// ------------------------------------------------------------------
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		item_t nxt;
		bit    took;
		bit    v;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			req_type   <= otm_pkg::REQ_TEMPLATE;
			char_code  <= 8'h00;
			last       <= 1'b0;
			burst_left = 8;
			gap_left   = 0;
		end else begin
			took = in_valid && in_ready;
			if (took)
				predict_match(req_type, char_code, last);
			if (!in_valid || took) begin
				v = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_q.size() != 0 &&
				             !(pend_q[0].drain && expected_q.size() != 0)) begin
					nxt = pend_q.pop_front();
					v   = 1'b1;
					req_type  <= nxt.rq;
					char_code <= nxt.ch;
					last      <= nxt.lst;
					if (nxt.hold)
						hold_toggle <= ~hold_toggle;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				in_valid <= v;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: ready pattern chosen at random and changed periodically, plus one long hold-off
	// ------------------------------------------------------------------
	int   rx_cycle;
	int   rx_style;
	int   hold_left;
	logic hold_seen;

	always @(posedge clk or negedge arst_n) begin
		bit rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle  = 0;
			rx_style  = 0;
			hold_left = 0;
			hold_seen = 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 256 == 0)
				rx_style = $urandom_range(0, 3);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_style)
					0:       rdy = 1'b1;
					1:       rdy = 1'($urandom_range(0, 1));
					2:       rdy = (rx_cycle % 4 == 0);
					default: rdy = ($urandom_range(0, 9) != 0);
				endcase
			end
			out_ready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: each result transaction against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		otm_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_error($sformatf("unexpected result kind=%0d matched=%0d idx=%0d",
				                       kind, matched, arg_index));
			end else begin
				want = expected_q.pop_front();
				if (kind !== want.kind)
					report_error($sformatf("kind %0d, want %0d", kind, want.kind));
				if (matched !== want.matched)
					report_error($sformatf("matched %0d, want %0d", matched, want.matched));
				if (arg_index !== want.arg_index)
					report_error($sformatf("arg_index %0d, want %0d", arg_index, want.arg_index));
				if (arg_start !== want.arg_start)
					report_error($sformatf("arg_start %0d, want %0d", arg_start, want.arg_start));
				if (arg_length !== want.arg_length)
					report_error($sformatf("arg_length %0d, want %0d",
					                       arg_length, want.arg_length));
				if (run_end !== want.run_end)
					report_error($sformatf("run_end %0d, want %0d", run_end, want.run_end));
			end
		end
	end

	// watchdog: too long without any transaction on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		byte_q_t tm;
		byte_q_t ln;
		byte_q_t part;
		int      base;
		bit      drain_done;

		tmpl_len     = 0;
		tmpl_loading = 1'b0;
		restart_line();

		// line before any template: nothing to match against
		queue_text(otm_pkg::REQ_SOURCE, "x", 1'b1);

		// literal, bracketed and quoted arguments; early end, extra text, mismatch
		queue_text(otm_pkg::REQ_TEMPLATE, "mov @,[@]", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "mov r1,[r2]", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "mov \"a,b\",[x]", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "mov 'q',[]", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "mov r1,[r2", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "mov r1,[r2]x", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "mvv r1", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "mov \"abc", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "mov ", 1'b1);

		// parenthesized argument followed by a rest capture
		queue_text(otm_pkg::REQ_TEMPLATE, "jp (@),@@", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "jp (hl),rest of it", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "jp (ix),", 1'b1);

		// no closing bracket: a zero byte ends the argument
		queue_text(otm_pkg::REQ_TEMPLATE, "x @", 1'b1);
		ln.delete();
		add_text(ln, "x ab");
		put_byte(ln, 8'h00);
		add_text(ln, "cd");
		queue_bytes(otm_pkg::REQ_SOURCE, ln, 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "x ab", 1'b1);

		// a line one past the source limit
		queue_text(otm_pkg::REQ_TEMPLATE, "@@", 1'b1);
		ln.delete();
		repeat (SLIMIT + 1)
			put_byte(ln, 8'($urandom_range(0, 255)));
		queue_bytes(otm_pkg::REQ_SOURCE, ln, 1'b1);

		// 32 arguments in one line, with the receiver held off meanwhile
		tm.delete();
		ln.delete();
		for (int k = 0; k < 32; k++) begin
			if (k > 0) begin
				put_byte(tm, otm_pkg::CH_COMMA);
				put_byte(ln, otm_pkg::CH_COMMA);
			end
			put_byte(tm, otm_pkg::CH_AT);
			put_byte(ln, 8'h61 + 8'(k % 26));
		end
		hold_next = 1'b1;
		queue_bytes(otm_pkg::REQ_TEMPLATE, tm, 1'b1);
		queue_bytes(otm_pkg::REQ_SOURCE, ln, 1'b1);

		// template longer than the store: the tail is dropped
		tm.delete();
		repeat (TDEPTH + 6)
			put_byte(tm, 8'h61 + 8'($urandom_range(0, 25)));
		queue_bytes(otm_pkg::REQ_TEMPLATE, tm, 1'b1);
		ln = tm[0:TDEPTH - 1];
		queue_bytes(otm_pkg::REQ_SOURCE, ln, 1'b1);

		// template reload in the middle of a line
		queue_text(otm_pkg::REQ_TEMPLATE, "ld @", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "ld", 1'b0);
		queue_text(otm_pkg::REQ_TEMPLATE, "ld @", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "ld a", 1'b1);

		// a source character between template parts starts a new template
		queue_text(otm_pkg::REQ_TEMPLATE, "ab", 1'b0);
		queue_text(otm_pkg::REQ_SOURCE, "a", 1'b1);
		queue_text(otm_pkg::REQ_TEMPLATE, "cd", 1'b1);
		queue_text(otm_pkg::REQ_SOURCE, "cd", 1'b1);

		// random templates, each with a few lines
		base       = pend_q.size();
		drain_next = 1'b1;
		drain_done = 1'b0;
		while (pend_q.size() < base + RAND_ITEMS) begin
			if (!drain_done && pend_q.size() >= base + RAND_ITEMS / 2) begin
				drain_next = 1'b1;
				drain_done = 1'b1;
			end
			tm = gen_template();
			queue_bytes(otm_pkg::REQ_TEMPLATE, tm, $urandom_range(0, 19) != 0);
			repeat ($urandom_range(1, 5)) begin
				ln = gen_line(tm);
				case ($urandom_range(0, 24))
					0: ln[$urandom_range(0, ln.size() - 1)] = 8'($urandom_range(0, 255));
					1: while (ln.size() > 1 && $urandom_range(0, 1)) void'(ln.pop_back());
					2: repeat ($urandom_range(1, 3)) put_byte(ln, 8'($urandom_range(0, 255)));
					3: begin
						ln.delete();
						repeat ($urandom_range(1, 10))
							put_byte(ln, 8'($urandom_range(0, 255)));
					end
					4: begin
						// abandon a partial line by reloading the template
						part = ln;
						while (part.size() > 1 && $urandom_range(0, 1))
							void'(part.pop_back());
						queue_bytes(otm_pkg::REQ_SOURCE, part, 1'b0);
						queue_bytes(otm_pkg::REQ_TEMPLATE, tm, 1'b1);
					end
					default: ;
				endcase
				queue_bytes(otm_pkg::REQ_SOURCE, ln, 1'b1);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
hdl/otm_pkg.sv
hdl/otm_tmpl_mem.sv
hdl/otm_scan.sv
hdl/otm_res_fifo.sv
hdl/operand_template_matcher_core.sv
sim/tb_operand_template_matcher_core.sv
